FILE: rtl/rss_pkg.sv
// rss_pkg: shared constants, key codes and controller/datapath link types
// for the record selection sorter. No dependencies.
package rss_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int NAME_BYTES  = 32;
  localparam int WORD_W      = 64;
  localparam int NAME_WORDS  = NAME_BYTES / 8;
  localparam int NAME_W      = NAME_BYTES * 8;
  localparam int ATTR_W      = 6;
  localparam int KEY_W       = 3;

  // sort key codes
  localparam logic [KEY_W-1:0] KEY_NAME      = 3'd0;
  localparam logic [KEY_W-1:0] KEY_COLOR     = 3'd1;
  localparam logic [KEY_W-1:0] KEY_ANNUAL    = 3'd2;
  localparam logic [KEY_W-1:0] KEY_PERENNIAL = 3'd3;
  localparam logic [KEY_W-1:0] KEY_TROPICAL  = 3'd4;

  // attribute word layout
  localparam int ATTR_ANNUAL    = 3;
  localparam int ATTR_PERENNIAL = 4;
  localparam int ATTR_TROPICAL  = 5;

  typedef struct packed {
    logic             load_we;
    logic [IDX_W-1:0] load_idx;
    logic             swap_k;
    logic             swap_i;
    logic [IDX_W-1:0] pass_idx;
    logic             issue;
    logic             first;
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] pos;
  } rss_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } rss_stat_t;

endpackage

FILE: rtl/rss_ram.sv
// rss_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/rss_cmp.sv
// rss_cmp: decides whether a candidate record orders strictly before the
// current pick under the selected key. Uses rss_pkg.
module rss_cmp
  import rss_pkg::*;
(
  input  logic [KEY_W-1:0]  sort_key,
  input  logic [NAME_W-1:0] cand_name,
  input  logic [ATTR_W-1:0] cand_attr,
  input  logic [NAME_W-1:0] pick_name,
  input  logic [ATTR_W-1:0] pick_attr,
  output logic              precedes
);

  // per word: done when a differing byte or a shared terminator is seen
  logic [NAME_WORDS-1:0] word_done;
  logic [NAME_WORDS-1:0] word_lt;
  logic                  name_lt;

  always_comb begin
    logic [7:0] ca;
    logic [7:0] cb;
    for (int w = 0; w < NAME_WORDS; w++) begin
      word_done[w] = 1'b0;
      word_lt[w]   = 1'b0;
      for (int b = 0; b < 8; b++) begin
        ca = cand_name[NAME_W - 1 - (w * 64) - (b * 8) -: 8];
        cb = pick_name[NAME_W - 1 - (w * 64) - (b * 8) -: 8];
        if (!word_done[w]) begin
          if (ca != cb) begin
            word_done[w] = 1'b1;
            word_lt[w]   = (ca < cb);
          end else if (ca == 8'd0) begin
            word_done[w] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    logic done;
    done    = 1'b0;
    name_lt = 1'b0;
    for (int w = 0; w < NAME_WORDS; w++) begin
      if (!done && word_done[w]) begin
        done    = 1'b1;
        name_lt = word_lt[w];
      end
    end
  end

  always_comb begin
    case (sort_key)
      KEY_NAME:      precedes = name_lt;
      KEY_COLOR:     precedes = (cand_attr[2:0] < pick_attr[2:0]);
      KEY_ANNUAL:    precedes = cand_attr[ATTR_ANNUAL] & ~pick_attr[ATTR_ANNUAL];
      KEY_PERENNIAL: precedes = cand_attr[ATTR_PERENNIAL] & ~pick_attr[ATTR_PERENNIAL];
      KEY_TROPICAL:  precedes = cand_attr[ATTR_TROPICAL] & ~pick_attr[ATTR_TROPICAL];
      default:       precedes = 1'b0;
    endcase
  end

endmodule

FILE: rtl/rss_dp.sv
// rss_dp: record, attribute and order RAMs, the two-stage read pipeline,
// the pick registers and the key register. Uses rss_pkg, rss_ram, rss_cmp.
module rss_dp
  import rss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  rss_cmd_t            cmd,
  output rss_stat_t           stat,
  input  logic                cfg_we,
  input  logic [KEY_W-1:0]    cfg_data,
  input  logic [WORD_W-1:0]   in_name_word0,
  input  logic [WORD_W-1:0]   in_name_word1,
  input  logic [WORD_W-1:0]   in_name_word2,
  input  logic [WORD_W-1:0]   in_name_word3,
  input  logic [2:0]          in_color_code,
  input  logic                in_is_annual,
  input  logic                in_is_perennial,
  input  logic                in_is_tropical,
  output logic                out_valid,
  output logic [WORD_W-1:0]   out_name_word0,
  output logic [WORD_W-1:0]   out_name_word1,
  output logic [WORD_W-1:0]   out_name_word2,
  output logic [WORD_W-1:0]   out_name_word3,
  output logic [2:0]          out_color_code,
  output logic                out_annual,
  output logic                out_perennial,
  output logic                out_tropical,
  output logic                out_last
);

  logic [KEY_W-1:0] key_r;

  // pipeline: stage 1 = order entry read, stage 2 = record read
  logic             v1_r, first1_r, emit1_r, last1_r;
  logic [IDX_W-1:0] pos1_r;
  logic             v2_r, first2_r, emit2_r, last2_r;
  logic [IDX_W-1:0] pos2_r, idx2_r;

  logic [NAME_W-1:0] pick_name_r;
  logic [ATTR_W-1:0] pick_attr_r;
  logic [IDX_W-1:0]  pick_idx_r, pick_pos_r, first_idx_r;

  logic [IDX_W-1:0]  ord_q;
  logic [NAME_W-1:0] name_q;
  logic [ATTR_W-1:0] attr_q;
  logic              ord_we;
  logic [IDX_W-1:0]  ord_waddr, ord_wdata;
  logic              precedes;
  logic              take;

  always_comb begin
    ord_we    = cmd.load_we | cmd.swap_k | cmd.swap_i;
    ord_waddr = cmd.load_idx;
    ord_wdata = cmd.load_idx;
    if (cmd.swap_k) begin
      ord_waddr = pick_pos_r;
      ord_wdata = first_idx_r;
    end else if (cmd.swap_i) begin
      ord_waddr = cmd.pass_idx;
      ord_wdata = pick_idx_r;
    end
  end

  rss_ram #(.WIDTH(IDX_W), .DEPTH(MAX_RECORDS)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (cmd.pos),
    .rdata (ord_q)
  );

  rss_ram #(.WIDTH(NAME_W), .DEPTH(MAX_RECORDS)) u_name_ram (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (cmd.load_idx),
    .wdata ({in_name_word0, in_name_word1, in_name_word2, in_name_word3}),
    .raddr (ord_q),
    .rdata (name_q)
  );

  rss_ram #(.WIDTH(ATTR_W), .DEPTH(MAX_RECORDS)) u_attr_ram (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (cmd.load_idx),
    .wdata ({in_is_tropical, in_is_perennial, in_is_annual, in_color_code}),
    .raddr (ord_q),
    .rdata (attr_q)
  );

  rss_cmp u_cmp (
    .sort_key  (key_r),
    .cand_name (name_q),
    .cand_attr (attr_q),
    .pick_name (pick_name_r),
    .pick_attr (pick_attr_r),
    .precedes  (precedes)
  );

  assign take = v2_r & ~emit2_r & (first2_r | precedes);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= KEY_NAME;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_r <= cfg_data;
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= cmd.first;
    emit1_r  <= cmd.emit;
    last1_r  <= cmd.last;
    pos1_r   <= cmd.pos;
    first2_r <= first1_r;
    emit2_r  <= emit1_r;
    last2_r  <= last1_r;
    pos2_r   <= pos1_r;
    idx2_r   <= ord_q;
    if (take) begin
      pick_name_r <= name_q;
      pick_attr_r <= attr_q;
      pick_idx_r  <= idx2_r;
      pick_pos_r  <= pos2_r;
    end
    if (v2_r && first2_r && !emit2_r) begin
      first_idx_r <= idx2_r;
    end
  end

  assign stat.pipe_busy = v1_r | v2_r;

  assign out_valid      = v2_r & emit2_r;
  assign out_last       = last2_r;
  assign out_name_word0 = name_q[NAME_W-1 -: WORD_W];
  assign out_name_word1 = name_q[NAME_W-1-WORD_W -: WORD_W];
  assign out_name_word2 = name_q[NAME_W-1-2*WORD_W -: WORD_W];
  assign out_name_word3 = name_q[NAME_W-1-3*WORD_W -: WORD_W];
  assign out_color_code = attr_q[2:0];
  assign out_annual     = attr_q[ATTR_ANNUAL];
  assign out_perennial  = attr_q[ATTR_PERENNIAL];
  assign out_tropical   = attr_q[ATTR_TROPICAL];

endmodule

FILE: rtl/rss_ctrl.sv
// rss_ctrl: sequencer for load, selection-sort passes and sorted output.
// Uses rss_pkg; drives rss_dp through rss_cmd_t.
module rss_ctrl
  import rss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_last_record,
  output logic      busy,
  output rss_cmd_t  cmd,
  input  rss_stat_t stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SWAPK = 3'd2;
  localparam logic [2:0] S_SWAPI = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pass_r, pass_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] pass_ext;
  logic             room;

  assign busy     = (state_r != S_IDLE);
  assign pass_ext = {1'b0, pass_r};
  assign room     = (count_r < CNT_W'(MAX_RECORDS));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pass_nxt  = pass_r;
    pos_nxt   = pos_r;

    cmd.load_we  = 1'b0;
    cmd.load_idx = count_r[IDX_W-1:0];
    cmd.swap_k   = 1'b0;
    cmd.swap_i   = 1'b0;
    cmd.pass_idx = pass_r;
    cmd.issue    = 1'b0;
    cmd.first    = (pos_r == pass_ext);
    cmd.emit     = 1'b0;
    cmd.last     = ((pos_r + CNT_W'(1)) == count_r);
    cmd.pos      = pos_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (room) begin
            cmd.load_we = 1'b1;
            count_nxt   = count_r + CNT_W'(1);
          end
          if (in_last_record) begin
            pos_nxt  = '0;
            pass_nxt = '0;
            state_nxt = (count_nxt <= CNT_W'(1)) ? S_EMIT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pos_r < count_r) begin
          cmd.issue = 1'b1;
          pos_nxt   = pos_r + CNT_W'(1);
        end else if (!stat.pipe_busy) begin
          state_nxt = S_SWAPK;
        end
      end
      S_SWAPK: begin
        cmd.swap_k = 1'b1;
        state_nxt  = S_SWAPI;
      end
      S_SWAPI: begin
        cmd.swap_i = 1'b1;
        if ((pass_ext + CNT_W'(2)) >= count_r) begin
          pos_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          pass_nxt  = pass_r + IDX_W'(1);
          pos_nxt   = pass_ext + CNT_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_EMIT: begin
        if (pos_r < count_r) begin
          cmd.issue = 1'b1;
          cmd.emit  = 1'b1;
          pos_nxt   = pos_r + CNT_W'(1);
        end else if (!stat.pipe_busy) begin
          count_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pass_r  <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pass_r  <= pass_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

FILE: rtl/record_selection_sort.sv
// record_selection_sort: loads one record per beat; a beat marked last starts
// a selection sort by the configured key, then all n records leave in order.
// Loading: one beat per cycle while busy is low. Sort: per pass i a scan of
// n-i entries through a 2-stage RAM read pipeline plus a swap of two order-table
// writes; output then streams one beat per cycle through the same pipeline.
// Results cannot be stalled.
// Reset (synchronous, rst_n low) empties the set and sets the key to name.
module record_selection_sort
  import rss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic [KEY_W-1:0]  cfg_data,
  // input beats
  input  logic              start,
  output logic              busy,
  input  logic [WORD_W-1:0] in_name_word0,
  input  logic [WORD_W-1:0] in_name_word1,
  input  logic [WORD_W-1:0] in_name_word2,
  input  logic [WORD_W-1:0] in_name_word3,
  input  logic [2:0]        in_color_code,
  input  logic              in_is_annual,
  input  logic              in_is_perennial,
  input  logic              in_is_tropical,
  input  logic              in_last_record,
  // result beats
  output logic              out_valid,
  output logic [WORD_W-1:0] out_name_word0,
  output logic [WORD_W-1:0] out_name_word1,
  output logic [WORD_W-1:0] out_name_word2,
  output logic [WORD_W-1:0] out_name_word3,
  output logic [2:0]        out_color_code,
  output logic              out_annual,
  output logic              out_perennial,
  output logic              out_tropical,
  output logic              out_last
);

  // The controller owns the record count, pass index and scan position.
  // The order table is seeded during load (entry r = r), so no fill sweep is
  // needed before sorting. Each scan streams order entries from the pass
  // index to the end; the first one seeds the pick, later ones replace it
  // when they order strictly before it. The swap then takes two order-table
  // writes. A record beat with the set full is dropped, but its last mark
  // still starts the sort. Stores are not cleared: only written entries are
  // ever read.
  rss_cmd_t  cmd;
  rss_stat_t stat;

  rss_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_last_record (in_last_record),
    .busy           (busy),
    .cmd            (cmd),
    .stat           (stat)
  );

  rss_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_name_word0   (in_name_word0),
    .in_name_word1   (in_name_word1),
    .in_name_word2   (in_name_word2),
    .in_name_word3   (in_name_word3),
    .in_color_code   (in_color_code),
    .in_is_annual    (in_is_annual),
    .in_is_perennial (in_is_perennial),
    .in_is_tropical  (in_is_tropical),
    .out_valid       (out_valid),
    .out_name_word0  (out_name_word0),
    .out_name_word1  (out_name_word1),
    .out_name_word2  (out_name_word2),
    .out_name_word3  (out_name_word3),
    .out_color_code  (out_color_code),
    .out_annual      (out_annual),
    .out_perennial   (out_perennial),
    .out_tropical    (out_tropical),
    .out_last        (out_last)
  );

endmodule

FILE: tb/sv/tb_record_selection_sort.sv
// tb_record_selection_sort: self-checking bench for the record selection sorter.
// Needs rss_pkg and record_selection_sort; holds its own batch sorter to predict
// every output beat, plus directed and random batches under every named key and spares.
`timescale 1ns / 100ps

module tb_record_selection_sort
  import rss_pkg::*;
();

  // Sort keys the package leaves unnamed: they order nothing, so load order holds
  localparam logic [KEY_W-1:0] KEY_SPARE_LO = 3'd5;
  localparam logic [KEY_W-1:0] KEY_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 64;
  // Settle time before a key write, and tail wait at the end of the run
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 40;
  // Watchdog limit: a full 64-record sort, and even many full batches sent with
  // gaps between beats, stay well below this
  localparam int CYCLE_LIMIT   = 1_500_000;

  typedef logic [NAME_W-1:0] name_t;

  typedef struct packed {
    name_t      name;
    logic [2:0] color;
    logic       annual;
    logic       perennial;
    logic       tropical;
  } record_t;

  typedef struct packed {
    record_t rec;
    logic    last;
  } sorted_beat_t;

  logic              clk;
  logic              rst_n           = 1'b0;
  logic              cfg_we          = 1'b0;
  logic [KEY_W-1:0]  cfg_data        = '0;
  logic              start           = 1'b0;
  logic              busy;
  logic [WORD_W-1:0] in_name_word0   = '0;
  logic [WORD_W-1:0] in_name_word1   = '0;
  logic [WORD_W-1:0] in_name_word2   = '0;
  logic [WORD_W-1:0] in_name_word3   = '0;
  logic [2:0]        in_color_code   = '0;
  logic              in_is_annual    = 1'b0;
  logic              in_is_perennial = 1'b0;
  logic              in_is_tropical  = 1'b0;
  logic              in_last_record  = 1'b0;
  logic              out_valid;
  logic [WORD_W-1:0] out_name_word0;
  logic [WORD_W-1:0] out_name_word1;
  logic [WORD_W-1:0] out_name_word2;
  logic [WORD_W-1:0] out_name_word3;
  logic [2:0]        out_color_code;
  logic              out_annual;
  logic              out_perennial;
  logic              out_tropical;
  logic              out_last;

  record_selection_sort u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .in_name_word0   (in_name_word0),
    .in_name_word1   (in_name_word1),
    .in_name_word2   (in_name_word2),
    .in_name_word3   (in_name_word3),
    .in_color_code   (in_color_code),
    .in_is_annual    (in_is_annual),
    .in_is_perennial (in_is_perennial),
    .in_is_tropical  (in_is_tropical),
    .in_last_record  (in_last_record),
    .out_valid       (out_valid),
    .out_name_word0  (out_name_word0),
    .out_name_word1  (out_name_word1),
    .out_name_word2  (out_name_word2),
    .out_name_word3  (out_name_word3),
    .out_color_code  (out_color_code),
    .out_annual      (out_annual),
    .out_perennial   (out_perennial),
    .out_tropical    (out_tropical),
    .out_last        (out_last)
  );

  // Bench copy of the block state: records loaded so far and the active key
  record_t          loaded_set[$];
  sorted_beat_t     sorted_expect[$];
  logic [KEY_W-1:0] active_key = KEY_NAME;   // key after reset is name

  int errors      = 0;
  int cycle_count = 0;
  bit burst       = 1'b0;   // when set, the sender never idles between beats

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung sorter or a lost beat ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Byte-wise unsigned compare; stops at the first difference or shared zero,
  // so anything after a terminator is ignored
  function automatic bit name_precedes(name_t a, name_t b);
    logic [7:0] ca, cb;
    for (int i = 0; i < NAME_BYTES; i++) begin
      ca = a[NAME_W-1-8*i -: 8];
      cb = b[NAME_W-1-8*i -: 8];
      if (ca != cb) return ca < cb;
      if (ca == 8'h00) return 1'b0;
    end
    return 1'b0;
  endfunction

  // Strict ordering under the key; flags sort with yes first
  function automatic bit comes_before(record_t a, record_t b, logic [KEY_W-1:0] key);
    case (key)
      KEY_NAME:      return name_precedes(a.name, b.name);
      KEY_COLOR:     return a.color < b.color;
      KEY_ANNUAL:    return a.annual & ~b.annual;
      KEY_PERENNIAL: return a.perennial & ~b.perennial;
      KEY_TROPICAL:  return a.tropical & ~b.tropical;
      default:       return 1'b0;
    endcase
  endfunction

  // Called once per accepted beat. A full store drops the record but a last
  // mark on it still releases the sort. Plain selection sort, not stable: the
  // pick only moves on a strict win, then swaps into place.
  function automatic void predict_sorted_batch(record_t r, bit last);
    int           order[$];
    int           n, k, t;
    sorted_beat_t beat;
    if (loaded_set.size() < MAX_RECORDS) loaded_set.push_back(r);
    if (!last) return;
    n = loaded_set.size();
    for (int i = 0; i < n; i++) order.push_back(i);
    for (int i = 0; i < n; i++) begin
      k = i;
      for (int j = i + 1; j < n; j++)
        if (comes_before(loaded_set[order[j]], loaded_set[order[k]], active_key)) k = j;
      t        = order[k];
      order[k] = order[i];
      order[i] = t;
    end
    for (int i = 0; i < n; i++) begin
      beat.rec  = loaded_set[order[i]];
      beat.last = (i == n - 1);
      sorted_expect.push_back(beat);
    end
    loaded_set.delete();
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobed beat is taken against the oldest expectation
  // ---------------------------------------------------------------------------

  function automatic bit field_ok(string fname, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : check_results
    sorted_beat_t want;
    bit           ok;
    if (rst_n && out_valid) begin
      if (sorted_expect.size() == 0) begin
        $display("%0t: result beat with nothing expected: expected none, actual name %0h",
                 $time, out_name_word0);
        errors++;
      end else begin
        want = sorted_expect.pop_front();
        ok   = 1'b1;
        ok  &= field_ok("name_word0", want.rec.name[NAME_W-1 -: WORD_W], out_name_word0);
        ok  &= field_ok("name_word1", want.rec.name[NAME_W-1-WORD_W -: WORD_W],
                        out_name_word1);
        ok  &= field_ok("name_word2", want.rec.name[NAME_W-1-2*WORD_W -: WORD_W],
                        out_name_word2);
        ok  &= field_ok("name_word3", want.rec.name[WORD_W-1:0], out_name_word3);
        ok  &= field_ok("color_code", 64'(want.rec.color), 64'(out_color_code));
        ok  &= field_ok("annual", 64'(want.rec.annual), 64'(out_annual));
        ok  &= field_ok("perennial", 64'(want.rec.perennial), 64'(out_perennial));
        ok  &= field_ok("tropical", 64'(want.rec.tropical), 64'(out_tropical));
        ok  &= field_ok("last", 64'(want.last), 64'(out_last));
        if (!ok) errors++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one record beat. start is only lowered when a gap is drawn, so a
  // back-to-back beat never sees two assignments to start in one step.
  task automatic load_record(record_t r, bit last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_name_word0   <= r.name[NAME_W-1 -: WORD_W];
    in_name_word1   <= r.name[NAME_W-1-WORD_W -: WORD_W];
    in_name_word2   <= r.name[NAME_W-1-2*WORD_W -: WORD_W];
    in_name_word3   <= r.name[WORD_W-1:0];
    in_color_code   <= r.color;
    in_is_annual    <= r.annual;
    in_is_perennial <= r.perennial;
    in_is_tropical  <= r.tropical;
    in_last_record  <= last;
    // beat taken at the first edge that sees busy low
    do @(posedge clk); while (busy !== 1'b0);
    predict_sorted_batch(r, last);
  endtask

  // Lets the sorter run dry; every batch ends in a last beat so an empty
  // expectation queue means the block is done bar its own wind-down
  task automatic wait_output_drained();
    start <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sort_key(logic [KEY_W-1:0] key);
    wait_output_drained();
    cfg_we   <= 1'b1;
    cfg_data <= key;
    @(posedge clk);
    cfg_we     <= 1'b0;
    active_key  = key;
  endtask

  function automatic name_t name_from_text(string s);
    name_t nm = '0;
    for (int i = 0; i < s.len() && i < NAME_BYTES; i++) nm[NAME_W-1-8*i -: 8] = s[i];
    return nm;
  endfunction

  // len copies of fill, then tail in the next byte if there is room
  function automatic name_t run_name(int len, logic [7:0] fill, logic [7:0] tail);
    name_t nm = '0;
    for (int i = 0; i < len; i++) nm[NAME_W-1-8*i -: 8] = fill;
    if (len < NAME_BYTES) nm[NAME_W-1-8*len -: 8] = tail;
    return nm;
  endfunction

  function automatic record_t make_record(name_t nm, logic [2:0] color, logic [2:0] flags);
    record_t r;
    r.name      = nm;
    r.color     = color;
    r.annual    = flags[2];
    r.perennial = flags[1];
    r.tropical  = flags[0];
    return r;
  endfunction

  // Often short names over a tiny alphabet so ties and prefixes are common;
  // others are long, fully random, junk after a terminator, near-full ties or all 0/1
  function automatic name_t random_name();
    name_t nm = '0;
    int    len, mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2, 3: begin
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++)
          nm[NAME_W-1-8*i -: 8] = 8'h61 + 8'($urandom_range(0, 2));
      end
      4, 5: begin
        len = $urandom_range(0, NAME_BYTES);
        for (int i = 0; i < len; i++) nm[NAME_W-1-8*i -: 8] = 8'($urandom_range(1, 255));
      end
      6: begin
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++)
          nm[NAME_W-1-8*i -: 8] = 8'h61 + 8'($urandom_range(0, 2));
        for (int i = len + 1; i < NAME_BYTES; i++)
          nm[NAME_W-1-8*i -: 8] = 8'($urandom_range(0, 255));
      end
      7: begin
        for (int i = 0; i < NAME_W / 32; i++) nm[32*i +: 32] = $urandom;
      end
      8: nm = run_name(NAME_BYTES - 1, 8'h61, 8'h61 + 8'($urandom_range(0, 1)));
      default: nm = ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
    return nm;
  endfunction

  function automatic record_t random_record();
    return make_record(random_name(), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Name order under the key left by reset: empty and all-ones names, prefix
  // against longer name, junk after a terminator, a difference in the final
  // byte, a full-length name and a top-bit byte. Then a one-record set.
  task automatic test_name_order();
    name_t junk;
    junk             = name_from_text("abc");
    junk[NAME_W-33:0] = {(NAME_BYTES - 4){8'hA5}};
    load_record(make_record('0, 3'd7, 3'b111), 1'b0);
    load_record(make_record('1, 3'd0, 3'b000), 1'b0);
    load_record(make_record(name_from_text("abc"), 3'd2, 3'b100), 1'b0);
    load_record(make_record(name_from_text("ab"), 3'd4, 3'b010), 1'b0);
    load_record(make_record(junk, 3'd5, 3'b001), 1'b0);
    load_record(make_record(run_name(NAME_BYTES - 1, 8'h61, 8'h62), 3'd1, 3'b110), 1'b0);
    load_record(make_record(run_name(NAME_BYTES, 8'h61, 8'h00), 3'd3, 3'b011), 1'b0);
    load_record(make_record(run_name(NAME_BYTES - 1, 8'h61, 8'h80), 3'd6, 3'b101), 1'b1);
    load_record(random_record(), 1'b1);
  endtask

  // Colour ascending with a duplicate pair, extremes 0 and 7 included
  task automatic test_color_order();
    set_sort_key(KEY_COLOR);
    load_record(make_record(name_from_text("p"), 3'd7, 3'b000), 1'b0);
    load_record(make_record(name_from_text("q"), 3'd3, 3'b111), 1'b0);
    load_record(make_record(name_from_text("r"), 3'd0, 3'b010), 1'b0);
    load_record(make_record(name_from_text("s"), 3'd3, 3'b101), 1'b0);
    load_record(make_record(name_from_text("t"), 3'd1, 3'b001), 1'b1);
  endtask

  // Each flag key once; the three patterns give every flag a yes and a no
  task automatic test_flag_order();
    logic [KEY_W-1:0] keys[3] = '{KEY_ANNUAL, KEY_PERENNIAL, KEY_TROPICAL};
    foreach (keys[k]) begin
      set_sort_key(keys[k]);
      load_record(make_record(name_from_text("x"), 3'd2, 3'b010), 1'b0);
      load_record(make_record(name_from_text("y"), 3'd4, 3'b101), 1'b0);
      load_record(make_record(name_from_text("z"), 3'd5, 3'b111), 1'b1);
    end
  endtask

  // Unnamed keys: output must come back in load order
  task automatic test_spare_keys();
    set_sort_key(KEY_SPARE_HI);
    for (int i = 0; i < 3; i++) load_record(random_record(), i == 2);
    set_sort_key(KEY_SPARE_LO);
    for (int i = 0; i < 2; i++) load_record(random_record(), i == 1);
  endtask

  // Overflow: 66 beats drop the last two, the dropped last one still releasing
  // the sort of a full store.
  task automatic test_store_full();
    set_sort_key(KEY_NAME);
    for (int i = 0; i < MAX_RECORDS + 2; i++)
      load_record(random_record(), i == MAX_RECORDS + 1);
  endtask

  // Random sets, mostly small; key changes between some sets, others follow
  // straight on while the previous set is still sorting
  task automatic test_random_batches();
    int sent = 0;
    int n, pick;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) != 0)
        set_sort_key(KEY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 4)));
      burst = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 19);
      if (pick < 16)      n = $urandom_range(1, 10);
      else if (pick < 19) n = $urandom_range(11, 24);
      else                n = $urandom_range(40, MAX_RECORDS);
      for (int i = 0; i < n; i++) load_record(random_record(), i == n - 1);
      sent += n;
    end
    burst = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_name_order();
    test_color_order();
    test_flag_order();
    test_spare_keys();
    test_store_full();
    test_random_batches();
    wait_output_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
